@@ src/assert_macros.svh @@
// assertion macros shared by the debouncer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/mcd_pkg.sv @@
// shared types and constants of the multi-channel input debouncer
`default_nettype none

package mcd_pkg;

	// field widths
	localparam int FieldW      = 3;
	localparam int TicksW      = 8;
	localparam int CfgIdxW     = 2;
	localparam int CfgDataW    = 8;
	localparam int NumChannels = 3;

	// reset values of the configuration registers
	localparam logic [TicksW-1:0] ResetTicks  = TicksW'(10);
	localparam logic [FieldW-1:0] ResetEnable = {FieldW{1'b1}};

	// register indexes
	localparam logic [CfgIdxW-1:0] CFG_TICKS  = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] CFG_ENABLE = CfgIdxW'(1);

	// item opcodes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// per channel phase
	typedef enum logic [3:0] {
		PH_LOW     = 4'b0001,
		PH_RISING  = 4'b0010,
		PH_HIGH    = 4'b0100,
		PH_FALLING = 4'b1000
	} phase_t;

	// what one lane reports for the item in flight
	typedef struct packed {
		logic changed;
		logic level;
		logic pending;
	} lane_res_t;

	// command from the top level to every lane
	typedef struct packed {
		logic              accept;
		logic              opcode;
		logic              resolve;
		logic [TicksW-1:0] ticks;
	} lane_cmd_t;

endpackage

`default_nettype wire

@@ src/multi_channel_input_debouncer.sv @@
// Multi-channel input debouncer, top level.
//
// One beat on the input channel (in_valid/in_stall) is either a pin level
// sample (opcode sample, pin_levels holds one bit per channel) or a timer
// tick. Every accepted beat yields exactly one result beat on the output
// channel (out_valid/out_stall) with changed_mask, level_mask, pending_mask.
// Each channel is a lane with its own phase register and settle countdown;
// all lanes act on the same beat in the same cycle.
// The result is registered in the output buffer before it is shown.
// Throughput: one beat per cycle unless stalled; a two-beat output buffer
// lets one more beat in while a result waits, and in_stall rises only when full.
// The configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready; the user must write it only while the block is idle, which
// the block does not enforce. Index 0 sets the tick length (0 is stored as 1),
// index 1 the enable mask; writing the mask settles every pending channel to
// its target level without a report. Reset: all channels stable low, countdowns
// idle, tick length 10, all channels debounced, output buffer empty.
`default_nettype none

module multi_channel_input_debouncer #(
	parameter int CHANNELS = mcd_pkg::NumChannels
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire                              opcode,
	input  wire  [mcd_pkg::FieldW-1:0]       pin_levels,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [mcd_pkg::FieldW-1:0]       changed_mask,
	output logic [mcd_pkg::FieldW-1:0]       level_mask,
	output logic [mcd_pkg::FieldW-1:0]       pending_mask,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [mcd_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire  [mcd_pkg::CfgDataW-1:0]     cfg_data
);
	import mcd_pkg::*;

	logic [TicksW-1:0] ticks_q;
	logic [FieldW-1:0] enable_q;
	logic              full;
	logic              cfg_wr;
	lane_cmd_t         cmd;
	lane_res_t         lane_res [CHANNELS];

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign in_stall  = full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q  <= ResetTicks;
			enable_q <= ResetEnable;
		end else if (cfg_wr) begin
			if (cfg_index == CFG_TICKS) begin
				ticks_q <= (cfg_data[TicksW-1:0] == '0) ? TicksW'(1) : cfg_data[TicksW-1:0];
			end else if (cfg_index == CFG_ENABLE) begin
				enable_q <= cfg_data[FieldW-1:0];
			end
		end
	end

	// command broadcast to all lanes
	assign cmd.accept  = in_valid && !in_stall;
	assign cmd.opcode  = opcode;
	assign cmd.resolve = cfg_wr && cfg_index == CFG_ENABLE;
	assign cmd.ticks   = ticks_q;

	// one lane per channel; channels past the field width see level 0, no debounce
	for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
		logic pin_i, en_i;
		if (i < FieldW) begin : g_pin
			assign pin_i = pin_levels[i];
			assign en_i  = enable_q[i];
		end else begin : g_zero
			assign pin_i = 1'b0;
			assign en_i  = 1'b0;
		end
		mcd_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.pin    (pin_i),
			.en     (en_i),
			.res    (lane_res[i])
		);
	end

	// merge lane results and buffer the output beat
	mcd_merge #(
		.CHANNELS (CHANNELS)
	) u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (cmd.accept),
		.lane_res     (lane_res),
		.full         (full),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.changed_mask (changed_mask),
		.level_mask   (level_mask),
		.pending_mask (pending_mask)
	);

endmodule

`default_nettype wire

@@ src/mcd_lane.sv @@
// one debounce channel: phase register, settle countdown and next-state logic
`default_nettype none

module mcd_lane (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire mcd_pkg::lane_cmd_t cmd,
	input  wire                     pin,
	input  wire                     en,
	output mcd_pkg::lane_res_t      res
);
	import mcd_pkg::*;

	`include "assert_macros.svh"

	phase_t            phase_q, phase_d;
	logic [TicksW-1:0] cnt_q, cnt_d;
	logic              changed;
	logic              is_sample, is_tick, last_tick;

	assign is_sample = cmd.opcode == OP_SAMPLE;
	assign is_tick   = cmd.opcode == OP_TICK && cnt_q != '0;
	assign last_tick = cnt_q == TicksW'(1);

	// next phase and countdown for the current item
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		changed = 1'b0;
		case (phase_q)
			PH_LOW: begin
				if (is_sample && pin) begin
					if (en) begin
						phase_d = PH_RISING;
						cnt_d   = cmd.ticks;
					end else begin
						phase_d = PH_HIGH;
						changed = 1'b1;
					end
				end
			end
			PH_RISING: begin
				if (is_sample && en && !pin) begin
					phase_d = PH_LOW;
					cnt_d   = '0;
				end else if (is_tick) begin
					cnt_d = cnt_q - TicksW'(1);
					if (last_tick) begin
						phase_d = PH_HIGH;
						changed = 1'b1;
					end
				end
			end
			PH_HIGH: begin
				if (is_sample && !pin) begin
					if (en) begin
						phase_d = PH_FALLING;
						cnt_d   = cmd.ticks;
					end else begin
						phase_d = PH_LOW;
						changed = 1'b1;
					end
				end
			end
			PH_FALLING: begin
				if (is_sample && en && pin) begin
					phase_d = PH_HIGH;
					cnt_d   = '0;
				end else if (is_tick) begin
					cnt_d = cnt_q - TicksW'(1);
					if (last_tick) begin
						phase_d = PH_LOW;
						changed = 1'b1;
					end
				end
			end
			default: begin
				phase_d = PH_LOW;
				cnt_d   = '0;
			end
		endcase
	end

	// state update: enable write resolves pending phases silently
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LOW;
			cnt_q   <= '0;
		end else if (cmd.resolve) begin
			cnt_q <= '0;
			if (phase_q == PH_RISING) begin
				phase_q <= PH_HIGH;
			end else if (phase_q == PH_FALLING) begin
				phase_q <= PH_LOW;
			end
		end else if (cmd.accept) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
		end
	end

	// result of this item, taken by the merge stage
	assign res.changed = changed;
	assign res.level   = phase_d == PH_HIGH || phase_d == PH_FALLING;
	assign res.pending = phase_d == PH_RISING || phase_d == PH_FALLING;

	`ASSERT_CLK(a_cnt_iff_pending, clk, arst_n,
		(phase_q == PH_RISING || phase_q == PH_FALLING) == (cnt_q != '0),
		"countdown running outside a pending phase")
	`ASSERT_NEXT(a_phase_hold, clk, arst_n, !cmd.accept && !cmd.resolve,
		$stable(phase_q), "phase moved without an item or enable write")
	`ASSERT_NEXT(a_changed_stable, clk, arst_n,
		cmd.accept && !cmd.resolve && res.changed,
		phase_q == PH_LOW || phase_q == PH_HIGH, "change reported into a pending phase")

endmodule

`default_nettype wire

@@ src/mcd_merge.sv @@
// merges lane results into masks and holds them in a two-beat output buffer
`default_nettype none

module mcd_merge #(
	parameter int CHANNELS = mcd_pkg::NumChannels
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             push,
	input  wire mcd_pkg::lane_res_t         lane_res [CHANNELS],
	output logic                            full,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic [mcd_pkg::FieldW-1:0]      changed_mask,
	output logic [mcd_pkg::FieldW-1:0]      level_mask,
	output logic [mcd_pkg::FieldW-1:0]      pending_mask
);
	import mcd_pkg::*;

	`include "assert_macros.svh"

	typedef struct packed {
		logic [FieldW-1:0] changed;
		logic [FieldW-1:0] level;
		logic [FieldW-1:0] pending;
	} beat_t;

	beat_t       merged;
	beat_t       buf_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;
	logic        pop;

	// gather lane bits; channels past the field width are dropped
	for (genvar i = 0; i < FieldW; i++) begin : g_gather
		if (i < CHANNELS) begin : g_lane
			assign merged.changed[i] = lane_res[i].changed;
			assign merged.level[i]   = lane_res[i].level;
			assign merged.pending[i] = lane_res[i].pending;
		end else begin : g_none
			assign merged.changed[i] = 1'b0;
			assign merged.level[i]   = 1'b0;
			assign merged.pending[i] = 1'b0;
		end
	end

	assign pop       = out_valid && !out_stall;
	assign full      = count_q == 2'd2;
	assign out_valid = count_q != 2'd0;

	// buffer storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= merged;
		end
	end

	// buffer pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign changed_mask = buf_q[rd_ptr_q].changed;
	assign level_mask   = buf_q[rd_ptr_q].level;
	assign pending_mask = buf_q[rd_ptr_q].pending;

	`ASSERT_CLK(a_count_range, clk, arst_n, count_q != 2'd3, "buffer count overflow")
	`ASSERT_CLK(a_no_push_full, clk, arst_n, !(push && full), "beat pushed into a full buffer")
	`ASSERT_NEXT(a_ptr_gap, clk, arst_n, push && !pop && count_q == 2'd0,
		wr_ptr_q != rd_ptr_q, "write pointer did not advance past read pointer")

endmodule

`default_nettype wire

@@ dv/mcd_report_checker.sv @@
// report checker for the multi-channel input debouncer: predicts every result beat and compares
module mcd_report_checker (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	input  wire                           in_stall,
	input  wire                           opcode,
	input  wire  [mcd_pkg::FieldW-1:0]    pin_levels,
	input  wire                           out_valid,
	input  wire                           out_stall,
	input  wire  [mcd_pkg::FieldW-1:0]    changed_mask,
	input  wire  [mcd_pkg::FieldW-1:0]    level_mask,
	input  wire  [mcd_pkg::FieldW-1:0]    pending_mask,
	input  wire                           cfg_valid,
	input  wire                           cfg_ready,
	input  wire  [mcd_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire  [mcd_pkg::CfgDataW-1:0]  cfg_data,
	output int                            mismatch_count,
	output int                            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import mcd_pkg::*;

	// one result beat as the block reports it
	typedef struct packed {
		logic [FieldW-1:0] changed;
		logic [FieldW-1:0] level;
		logic [FieldW-1:0] pending;
	} report_t;

	// shadow of the debouncer state and registers
	phase_t            lane_phase [NumChannels];
	logic [TicksW-1:0] lane_count [NumChannels];
	logic [TicksW-1:0] tick_len;
	logic [FieldW-1:0] enable_mask;

	report_t due_reports [$];
	report_t exp_rep;
	report_t act_rep;

	initial begin
		mismatch_count = 0;
		outstanding    = 0;
	end

	// state after reset
	function automatic void reset_shadow();
		int i;
		tick_len    = ResetTicks;
		enable_mask = ResetEnable;
		for (i = 0; i < NumChannels; i++) begin
			lane_phase[i] = PH_LOW;
			lane_count[i] = '0;
		end
	endfunction

	// register write: zero length becomes one, mask write settles every pending lane
	function automatic void apply_register(input logic [CfgIdxW-1:0] idx,
			input logic [CfgDataW-1:0] data);
		int i;
		case (idx)
			CFG_TICKS: begin
				tick_len = (data[TicksW-1:0] == '0) ? TicksW'(1) : data[TicksW-1:0];
			end
			CFG_ENABLE: begin
				enable_mask = data[FieldW-1:0];
				for (i = 0; i < NumChannels; i++) begin
					lane_count[i] = '0;
					if (lane_phase[i] == PH_RISING)
						lane_phase[i] = PH_HIGH;
					else if (lane_phase[i] == PH_FALLING)
						lane_phase[i] = PH_LOW;
				end
			end
			default: begin
			end
		endcase
	endfunction

	// advance every lane by one sample or tick and build the report it causes
	function automatic report_t debounce_step(input logic op, input logic [FieldW-1:0] pins);
		report_t rep;
		phase_t  ph;
		int      i;
		rep = '0;
		for (i = 0; i < NumChannels; i++) begin
			ph = lane_phase[i];
			if (op == OP_SAMPLE) begin
				if (enable_mask[i]) begin
					// debounced lane: enter or cancel a pending phase
					case (ph)
						PH_LOW: begin
							if (pins[i]) begin
								ph = PH_RISING;
								lane_count[i] = tick_len;
							end
						end
						PH_RISING: begin
							if (!pins[i]) begin
								ph = PH_LOW;
								lane_count[i] = '0;
							end
						end
						PH_HIGH: begin
							if (!pins[i]) begin
								ph = PH_FALLING;
								lane_count[i] = tick_len;
							end
						end
						PH_FALLING: begin
							if (pins[i]) begin
								ph = PH_HIGH;
								lane_count[i] = '0;
							end
						end
						default: begin
						end
					endcase
				end else begin
					// pass-through lane switches and reports at once
					if (ph == PH_LOW && pins[i]) begin
						ph = PH_HIGH;
						rep.changed[i] = 1'b1;
					end else if (ph == PH_HIGH && !pins[i]) begin
						ph = PH_LOW;
						rep.changed[i] = 1'b1;
					end
				end
			end else if (lane_count[i] != '0) begin
				// tick: count down and settle on expiry
				lane_count[i] = lane_count[i] - TicksW'(1);
				if (lane_count[i] == '0) begin
					if (ph == PH_RISING) begin
						ph = PH_HIGH;
						rep.changed[i] = 1'b1;
					end else if (ph == PH_FALLING) begin
						ph = PH_LOW;
						rep.changed[i] = 1'b1;
					end
				end
			end
			lane_phase[i] = ph;
			rep.level[i] = (ph == PH_HIGH || ph == PH_FALLING);
			rep.pending[i] = (ph == PH_RISING || ph == PH_FALLING);
		end
		return rep;
	endfunction

	// count a failure, print only the first ten
	task automatic note_miss(input string what, input report_t exp, input report_t act);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s: expected changed %b level %b pending %b", $realtime, what,
				exp.changed, exp.level, exp.pending);
			$display("%0t: %s: actual   changed %b level %b pending %b", $realtime, what,
				act.changed, act.level, act.pending);
		end
	endtask

	// watch all channels; results first, as they belong to earlier beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_shadow();
			due_reports.delete();
			outstanding = 0;
		end else begin
			if (out_valid && !out_stall) begin
				act_rep = {changed_mask, level_mask, pending_mask};
				if (due_reports.size() == 0) begin
					note_miss("result beat with none due", '0, act_rep);
				end else begin
					exp_rep = due_reports.pop_front();
					if (act_rep !== exp_rep) begin
						note_miss("result beat differs", exp_rep, act_rep);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				apply_register(cfg_index, cfg_data);
			end
			if (in_valid && !in_stall) begin
				due_reports.push_back(debounce_step(opcode, pin_levels));
			end
			outstanding = due_reports.size();
		end
	end
endmodule

@@ dv/tb_multi_channel_input_debouncer.sv @@
// testbench top for the multi-channel input debouncer: stimulus, idling and verdict
module tb_multi_channel_input_debouncer;
	timeunit 1ns;
	timeprecision 1ps;
	import mcd_pkg::*;

	// index that no register answers to
	localparam logic [CfgIdxW-1:0] CfgSpare = CfgIdxW'(3);
	localparam int ChunkItems = 82;
	localparam int Chunks     = 5;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                opcode = OP_SAMPLE;
	logic [FieldW-1:0]   pin_levels = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [FieldW-1:0]   changed_mask;
	logic [FieldW-1:0]   level_mask;
	logic [FieldW-1:0]   pending_mask;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	int                  mismatch_count;
	int                  outstanding;
	int                  stall_pct = 0;
	logic [FieldW-1:0]   pin_state = '0;
	logic                configured = 1'b0;

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	multi_channel_input_debouncer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.pin_levels   (pin_levels),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.changed_mask (changed_mask),
		.level_mask   (level_mask),
		.pending_mask (pending_mask),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	mcd_report_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.pin_levels     (pin_levels),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.changed_mask   (changed_mask),
		.level_mask     (level_mask),
		.pending_mask   (pending_mask),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	// receiver: stall a share of the cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= $urandom_range(99) < stall_pct;
		end
	end

	// send count beats, idling a share of the free cycles
	task automatic run_items(input int count, input int idle_pct);
		int sent;
		sent = 0;
		while (sent < count) begin
			@(posedge clk);
			if (in_valid && !in_stall) begin
				sent++;
			end
			// a stalled beat holds; otherwise present the next one or idle
			if (!in_valid || !in_stall) begin
				if (sent < count && $urandom_range(99) >= idle_pct) begin
					in_valid <= 1'b1;
					if ($urandom_range(99) < 45) begin
						opcode     <= OP_TICK;
						pin_levels <= FieldW'($urandom_range(7));
					end else begin
						pin_state = pin_state ^ (FieldW'($urandom) & FieldW'($urandom)
							& FieldW'($urandom));
						opcode     <= OP_SAMPLE;
						pin_levels <= pin_state;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	endtask

	// wait until no beat is pending and every result has left
	task automatic drain();
		@(posedge clk);
		while (in_valid || outstanding != 0) begin
			@(posedge clk);
		end
	endtask

	// one register write on the configuration channel
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// new tick length, sometimes a new enable mask or a write to a spare index
	task automatic reconfigure();
		logic [CfgDataW-1:0] len;
		len = CfgDataW'($urandom_range(4));
		if ($urandom_range(9) == 0) begin
			len = '1;
		end
		write_reg(CFG_TICKS, len);
		if ($urandom_range(1) == 0) begin
			write_reg(CFG_ENABLE, CfgDataW'($urandom_range(255)));
		end
		if ($urandom_range(3) == 0) begin
			write_reg(CfgSpare, CfgDataW'($urandom_range(255)));
		end
	endtask

	// one idling phase in chunks, registers changed between chunks
	task automatic run_phase(input int idle_pct, input int stall);
		int k;
		stall_pct = stall;
		for (k = 0; k < Chunks; k++) begin
			if (configured) begin
				drain();
				reconfigure();
			end
			configured = 1'b1;
			run_items(ChunkItems, idle_pct);
		end
	endtask

	// reset, phases and verdict
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		run_phase(0, 0);
		run_phase(56, 0);
		run_phase(0, 56);
		run_phase(10, 10);
		drain();
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// end a hung run
	initial begin
		#400_000;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
